// File: src/local_mean_threshold_defines.svh
// Assertion macros shared by the local mean threshold RTL.
`ifndef LOCAL_MEAN_THRESHOLD_DEFINES_SVH
`define LOCAL_MEAN_THRESHOLD_DEFINES_SVH

// Property checked on every rising edge of clk_i, off while rst_ni is low.
`define LMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a rising edge of clk_i.
`define LMT_ASSERT_NEVER(lbl, cond, msg) \
  `LMT_ASSERT(lbl, !(cond), msg)

`endif

// File: src/lmt_pkg.sv
// Shared constants and types of the local mean threshold block.
package lmt_pkg;

  localparam int unsigned RADIUS_DEF     = 3;
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned OUTQ_DEPTH_DEF = 8;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 12;
  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 12'd480;

  localparam logic [PIX_W-1:0] MASK_ON  = 8'd255;
  localparam logic [PIX_W-1:0] MASK_OFF = 8'd0;

  // Control flags that travel with a pixel down the pipeline.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } stage_t;

  typedef struct packed {
    logic [PIX_W-1:0] mask_value;
    logic             frame_end;
  } res_t;

endpackage

// File: src/lmt_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the mask output.
interface lmt_pix_if;
  logic                     valid;
  logic                     ready;
  logic [lmt_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lmt_res_if;
  logic                     valid;
  logic                     ready;
  logic [lmt_pkg::PIX_W-1:0] mask_value;
  logic                     frame_end;

  modport source (output valid, output mask_value, output frame_end, input ready);
  modport sink   (input valid, input mask_value, input frame_end, output ready);
endinterface

// File: src/lmt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lmt_linebuf.sv
// Raster position tracking, line store read-modify-write and column sums.
`include "local_mean_threshold_defines.svh"

module lmt_linebuf #(
  parameter int unsigned RADIUS    = lmt_pkg::RADIUS_DEF,
  parameter int unsigned MAX_WIDTH = lmt_pkg::MAX_WIDTH_DEF,
  localparam int unsigned LINES = 2 * RADIUS,
  localparam int unsigned SIDE  = LINES + 1,
  localparam int unsigned XW    = $clog2(MAX_WIDTH),
  localparam int unsigned CSW   = $clog2(SIDE * 255 + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               restart_i,
  input  logic [XW-1:0]                      wlast_i,
  input  logic [lmt_pkg::HEIGHT_REG_W-1:0]   hlast_i,
  input  logic                               take_i,
  input  logic [lmt_pkg::PIX_W-1:0]          pixel_i,
  output logic                               s1_valid_o,
  output lmt_pkg::stage_t                    col_flags_o,
  output logic [CSW-1:0]                     colsum_o,
  output logic [lmt_pkg::PIX_W-1:0]          cpix_o
);

  localparam int unsigned SLW = $clog2(LINES);
  localparam int unsigned WW  = LINES * lmt_pkg::PIX_W;
  localparam int unsigned YW  = lmt_pkg::HEIGHT_REG_W;

  logic [XW-1:0]  x_q, x_d;
  logic [YW-1:0]  y_q, y_d;
  logic [SLW-1:0] ys_q, ys_d;

  lmt_pkg::stage_t            s1_q, s2_q;
  logic [lmt_pkg::PIX_W-1:0]  s1_px_q;
  logic [XW-1:0]              s1_x_q;
  logic [SLW-1:0]             s1_ys_q;

  logic                       fwd_q;
  logic [WW-1:0]              fwd_word_q;

  logic [WW-1:0]              rd_word;
  logic [WW-1:0]              word;
  logic [WW-1:0]              wr_word;
  logic [lmt_pkg::PIX_W-1:0]  word_a [LINES];
  logic [lmt_pkg::PIX_W-1:0]  col_a  [LINES];
  logic [CSW-1:0]             colsum_d;
  logic [CSW-1:0]             colsum_q;
  logic [lmt_pkg::PIX_W-1:0]  cpix_q;
  logic                       emit, last;

  // Next raster position; the row slot follows the row modulo the line count.
  always_comb begin
    x_d  = x_q;
    y_d  = y_q;
    ys_d = ys_q;
    if (restart_i) begin
      x_d  = '0;
      y_d  = '0;
      ys_d = '0;
    end else if (take_i) begin
      if (x_q == wlast_i) begin
        x_d = '0;
        if (y_q == hlast_i) begin
          y_d  = '0;
          ys_d = '0;
        end else begin
          y_d  = y_q + YW'(1);
          ys_d = (ys_q == SLW'(LINES - 1)) ? '0 : ys_q + SLW'(1);
        end
      end else begin
        x_d = x_q + XW'(1);
      end
    end
  end

  assign emit = (x_q >= XW'(LINES)) && (y_q >= YW'(LINES));
  assign last = (x_q == wlast_i) && (y_q == hlast_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      ys_q <= '0;
      s1_q <= '0;
      s2_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      x_q  <= x_d;
      y_q  <= y_d;
      ys_q <= ys_d;
      s1_q.valid <= take_i;
      s1_q.emit  <= emit;
      s1_q.last  <= last;
      s2_q <= s1_q;
      // The word written this cycle is read back stale by a read of the same column.
      fwd_q <= take_i && s1_q.valid && (x_q == s1_x_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_px_q    <= pixel_i;
    s1_x_q     <= x_q;
    s1_ys_q    <= ys_q;
    fwd_word_q <= wr_word;
    colsum_q   <= colsum_d;
    cpix_q     <= col_a[RADIUS];
  end

  lmt_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_q.valid),
    .waddr_i (s1_x_q),
    .wdata_i (wr_word),
    .re_i    (take_i),
    .raddr_i (x_q),
    .rdata_o (rd_word)
  );

  assign word = fwd_q ? fwd_word_q : rd_word;

  // Column k of the window comes from row slot (row + k) modulo the line count.
  always_comb begin
    logic [SLW:0] slot;
    for (int j = 0; j < LINES; j++) begin
      word_a[j] = word[j*lmt_pkg::PIX_W +: lmt_pkg::PIX_W];
    end
    for (int k = 0; k < LINES; k++) begin
      slot = {1'b0, s1_ys_q} + (SLW+1)'(k);
      if (slot >= (SLW+1)'(LINES)) begin
        slot = slot - (SLW+1)'(LINES);
      end
      col_a[k] = word_a[slot[SLW-1:0]];
    end
  end

  // The current row replaces the oldest row in its slot.
  always_comb begin
    for (int j = 0; j < LINES; j++) begin
      wr_word[j*lmt_pkg::PIX_W +: lmt_pkg::PIX_W] =
        (SLW'(j) == s1_ys_q) ? s1_px_q : word_a[j];
    end
  end

  always_comb begin
    colsum_d = CSW'(s1_px_q);
    for (int k = 0; k < LINES; k++) begin
      colsum_d = colsum_d + CSW'(col_a[k]);
    end
  end

  assign s1_valid_o  = s1_q.valid;
  assign col_flags_o = s2_q;
  assign colsum_o    = colsum_q;
  assign cpix_o      = cpix_q;

  `LMT_ASSERT(a_col_in_range, x_q <= wlast_i, "column position beyond the row end")
  `LMT_ASSERT(a_row_in_range, y_q <= hlast_i, "row position beyond the frame end")
  `LMT_ASSERT(a_slot_in_range, ys_q < SLW'(LINES), "row slot beyond the line count")

endmodule

// File: src/lmt_window.sv
// Sliding window sum from column sums and the threshold decision.
module lmt_window #(
  parameter int unsigned RADIUS = lmt_pkg::RADIUS_DEF,
  localparam int unsigned SIDE  = 2 * RADIUS + 1,
  localparam int unsigned CSW   = $clog2(SIDE * 255 + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lmt_pkg::stage_t            col_flags_i,
  input  logic [CSW-1:0]             colsum_i,
  input  logic [lmt_pkg::PIX_W-1:0]  cpix_i,
  output logic                       s3_valid_o,
  output logic                       push_o,
  output lmt_pkg::res_t              res_o
);

  localparam int unsigned AREA = SIDE * SIDE;
  localparam int unsigned SW   = $clog2(AREA * 255 + 1);

  logic [CSW-1:0]            cs_q   [SIDE];
  logic [lmt_pkg::PIX_W-1:0] crow_q [RADIUS+1];
  logic [SW-1:0]             sum_q, sum_d;
  logic [SW-1:0]             thr;
  lmt_pkg::stage_t           s3_q;

  // The window moves one column: the new column sum plus the newest held ones.
  // Building the sum afresh lets data from never-written line entries leave
  // the window together with its column.
  always_comb begin
    sum_d = SW'(colsum_i);
    for (int i = 1; i < SIDE; i++) begin
      sum_d = sum_d + SW'(cs_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIDE; i++) begin
        cs_q[i] <= '0;
      end
      for (int i = 0; i <= RADIUS; i++) begin
        crow_q[i] <= '0;
      end
      sum_q <= '0;
      s3_q  <= '0;
    end else begin
      s3_q <= col_flags_i;
      if (col_flags_i.valid) begin
        for (int i = 0; i < SIDE - 1; i++) begin
          cs_q[i] <= cs_q[i+1];
        end
        cs_q[SIDE-1] <= colsum_i;
        for (int i = 0; i < RADIUS; i++) begin
          crow_q[i] <= crow_q[i+1];
        end
        crow_q[RADIUS] <= cpix_i;
        sum_q <= sum_d;
      end
    end
  end

  // floor(sum / AREA) >= center holds exactly when sum >= AREA * center.
  assign thr = SW'(AREA) * SW'(crow_q[0]);

  assign s3_valid_o       = s3_q.valid;
  assign push_o           = s3_q.valid && s3_q.emit;
  assign res_o.mask_value = (sum_q >= thr) ? lmt_pkg::MASK_ON : lmt_pkg::MASK_OFF;
  assign res_o.frame_end  = s3_q.last;

endmodule

// File: src/lmt_outq.sv
// Result queue that decouples the pixel pipeline from the output handshake.
`include "local_mean_threshold_defines.svh"

module lmt_outq #(
  parameter int unsigned DEPTH = lmt_pkg::OUTQ_DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lmt_pkg::res_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output lmt_pkg::res_t data_o,
  output logic [CW-1:0] count_o
);

  lmt_pkg::res_t mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_q];
  assign count_o = count_q;

  `LMT_ASSERT_NEVER(a_outq_overflow, push_i && !pop_i && (count_q == CW'(DEPTH)),
                    "result queue overflow")

endmodule

// File: src/local_mean_threshold.sv
// A result passes the s1, s2 and s3 stage registers and the result queue before it is valid.
// Throughput: one pixel per clock unless held off; one line RAM read and write per pixel.
// Pixels in flight plus queued results at the queue depth hold off input until results are taken.
// Reset: 640x480 frame, position at the frame start, window sums zero, queue empty.
// The line RAM is not cleared after reset; the block accepts pixels at once.
`include "local_mean_threshold_defines.svh"

module local_mean_threshold #(
  parameter int unsigned RADIUS     = lmt_pkg::RADIUS_DEF,
  parameter int unsigned MAX_WIDTH  = lmt_pkg::MAX_WIDTH_DEF,
  parameter int unsigned OUTQ_DEPTH = lmt_pkg::OUTQ_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lmt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lmt_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lmt_pix_if.sink                         pix_i,
  lmt_res_if.source                       res_o
);

  localparam int unsigned SIDE = 2 * RADIUS + 1;
  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned CSW  = $clog2(SIDE * 255 + 1);
  localparam int unsigned MWW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW   = (MWW > lmt_pkg::WIDTH_REG_W) ? MWW : lmt_pkg::WIDTH_REG_W;
  localparam int unsigned QCW  = $clog2(OUTQ_DEPTH + 1);
  localparam int unsigned OCW  = $clog2(OUTQ_DEPTH + 4);

  logic [lmt_pkg::WIDTH_REG_W-1:0]  width_q;
  logic [lmt_pkg::HEIGHT_REG_W-1:0] height_q;
  logic [EW-1:0]                    wz, wsat;
  logic [XW-1:0]                    wlast;
  logic [lmt_pkg::HEIGHT_REG_W-1:0] hlast;

  logic                       take;
  logic                       s1_valid, s3_valid;
  lmt_pkg::stage_t            col_flags;
  logic [CSW-1:0]             colsum;
  logic [lmt_pkg::PIX_W-1:0]  cpix;
  logic                       push, pop;
  lmt_pkg::res_t              res_in, res_head;
  logic [QCW-1:0]             q_count;
  logic [OCW-1:0]             outstanding;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lmt_pkg::RESET_WIDTH;
      height_q <= lmt_pkg::RESET_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmt_pkg::REG_IMAGE_WIDTH: begin
          width_q <= cfg_data_i[lmt_pkg::WIDTH_REG_W-1:0];
        end
        lmt_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= cfg_data_i[lmt_pkg::HEIGHT_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // A zero width counts as one pixel; a width above the line store saturates.
  assign wz    = EW'(width_q);
  assign wsat  = (wz == '0) ? EW'(1) : ((wz > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : wz);
  assign wlast = XW'(wsat - EW'(1));
  assign hlast = (height_q == '0) ? '0 : height_q - lmt_pkg::HEIGHT_REG_W'(1);

  // Every pixel in flight holds a queue slot until it leaves the pipeline.
  assign outstanding = OCW'(q_count) + OCW'(s1_valid) + OCW'(col_flags.valid)
                     + OCW'(s3_valid);
  assign pix_i.ready = (outstanding < OCW'(OUTQ_DEPTH));
  assign take        = pix_i.valid && pix_i.ready;

  lmt_linebuf #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_linebuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .wlast_i     (wlast),
    .hlast_i     (hlast),
    .take_i      (take),
    .pixel_i     (pix_i.pixel),
    .s1_valid_o  (s1_valid),
    .col_flags_o (col_flags),
    .colsum_o    (colsum),
    .cpix_o      (cpix)
  );

  lmt_window #(
    .RADIUS (RADIUS)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_flags_i (col_flags),
    .colsum_i    (colsum),
    .cpix_i      (cpix),
    .s3_valid_o  (s3_valid),
    .push_o      (push),
    .res_o       (res_in)
  );

  lmt_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res_in),
    .pop_i   (pop),
    .valid_o (res_o.valid),
    .data_o  (res_head),
    .count_o (q_count)
  );

  assign pop              = res_o.valid && res_o.ready;
  assign res_o.mask_value = res_head.mask_value;
  assign res_o.frame_end  = res_head.frame_end;

  `LMT_ASSERT(a_credit_bound, outstanding <= OCW'(OUTQ_DEPTH),
              "more pixels in flight than free result slots")

endmodule

// File: bench/tb_local_mean_threshold.sv
// Self-checking testbench for the local mean threshold block.
`timescale 1ns / 100ps

module tb_local_mean_threshold;
  import lmt_pkg::*;

  localparam int unsigned RAD         = RADIUS_DEF;
  localparam int unsigned NLINES      = 2 * RAD;
  localparam int unsigned SIDE        = 2 * RAD + 1;
  localparam int unsigned AREA        = SIDE * SIDE;
  localparam int unsigned MAXW        = MAX_WIDTH_DEF;
  localparam int unsigned PIX_MAX     = (1 << PIX_W) - 1;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned TARGET_PIX  = 850;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned REPORT_MAX  = 10;

  // Indexes past the register list; a write there only restarts the frame.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef enum logic [1:0] {STEP_PIXEL, STEP_WRITE, STEP_DRAIN} step_kind_e;
  typedef enum logic [1:0] {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_e;
  typedef enum logic [1:0] {FILL_NOISE, FILL_FLAT, FILL_TWO_LEVEL} fill_e;

  typedef struct {
    step_kind_e            kind;
    logic [PIX_W-1:0]      pixel;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    int unsigned           hold;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lmt_pix_if pix_if ();
  lmt_res_if res_if ();

  local_mean_threshold u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_if.sink),
    .res_o      (res_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the block state used to predict the masks.
  logic [PIX_W-1:0]        line_mem [NLINES][MAXW];
  logic [PIX_W-1:0]        win [SIDE][SIDE];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int unsigned             col_pos;
  int unsigned             row_pos;

  step_t       feed_q[$];
  res_t        mask_q[$];
  int unsigned n_pixels;
  int unsigned n_accepted;
  int unsigned n_writes;
  int unsigned n_results;
  int unsigned n_failures;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  logic        hold_armed;
  int unsigned stall_left;
  pace_e       sink_pace = PACE_STEADY;
  int unsigned cycle_cnt = 0;

  function automatic void clear_predictor();
    width_reg  = RESET_WIDTH;
    height_reg = RESET_HEIGHT;
    col_pos    = 0;
    row_pos    = 0;
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg = data[WIDTH_REG_W-1:0];
      REG_IMAGE_HEIGHT: height_reg = data[HEIGHT_REG_W-1:0];
      default: ;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Slide the window by one column, update the line store and, for an
  // interior position, queue the expected mask.
  function automatic void threshold_step(input logic [PIX_W-1:0] px);
    int unsigned w, h, x, y, sum;
    res_t        want;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAXW) w = MAXW;
    h = (height_reg == 0) ? 1 : height_reg;
    x = (col_pos >= w) ? w - 1 : col_pos;
    y = (row_pos >= h) ? h - 1 : row_pos;
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c + 1 < SIDE; c++) win[r][c] = win[r][c + 1];
    for (int k = 0; k < NLINES; k++) win[k][SIDE - 1] = line_mem[(y + k) % NLINES][x];
    win[NLINES][SIDE - 1] = px;
    line_mem[y % NLINES][x] = px;
    if (x >= NLINES && y >= NLINES) begin
      sum = 0;
      foreach (win[r, c]) sum += win[r][c];
      want.mask_value = (sum / AREA >= win[RAD][RAD]) ? MASK_ON : MASK_OFF;
      want.frame_end  = (x == w - 1 && y == h - 1);
      mask_q.push_back(want);
    end
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
      row_pos = y;
    end
  endfunction

  function automatic void check_mask(input res_t seen);
    res_t want;
    if (mask_q.size() == 0) begin
      n_failures++;
      if (n_failures <= REPORT_MAX)
        $display("result %0d arrived with none expected: mask %0d end %0b",
                 n_results, seen.mask_value, seen.frame_end);
    end else begin
      want = mask_q.pop_front();
      if (seen.mask_value !== want.mask_value || seen.frame_end !== want.frame_end) begin
        n_failures++;
        if (n_failures <= REPORT_MAX)
          $display("result %0d mismatch: expected mask %0d end %0b, got mask %0d end %0b",
                   n_results, want.mask_value, want.frame_end,
                   seen.mask_value, seen.frame_end);
      end
    end
  endfunction

  function automatic int unsigned draw_pause(input pace_e pace);
    case (pace)
      PACE_STEADY: return 0;
      PACE_LIGHT:  return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      default:     return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input fill_e fill,
                                                  input logic [PIX_W-1:0] base);
    int v;
    case (fill)
      FILL_NOISE: v = $urandom_range(0, PIX_MAX);
      FILL_FLAT:  v = int'(base) + int'($urandom_range(0, 6)) - 3;
      default:    v = $urandom_range(0, 1) ? PIX_MAX : 0;
    endcase
    if (v < 0) v = 0;
    if (v > PIX_MAX) v = PIX_MAX;
    return v[PIX_W-1:0];
  endfunction

  function automatic void push_pixel(input logic [PIX_W-1:0] px, input pace_e pace);
    step_t s;
    s.kind  = STEP_PIXEL;
    s.pixel = px;
    s.idx   = REG_IMAGE_WIDTH;
    s.data  = '0;
    s.hold  = draw_pause(pace);
    feed_q.push_back(s);
    n_pixels++;
  endfunction

  function automatic void push_write(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
    step_t s;
    s.kind  = STEP_WRITE;
    s.pixel = '0;
    s.idx   = idx;
    s.data  = data;
    s.hold  = 0;
    feed_q.push_back(s);
  endfunction

  // Holds the sender until every expected mask is back and the pipe is quiet.
  function automatic void push_drain();
    step_t s;
    s.kind  = STEP_DRAIN;
    s.pixel = '0;
    s.idx   = REG_IMAGE_WIDTH;
    s.data  = '0;
    s.hold  = 0;
    feed_q.push_back(s);
  endfunction

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  always @(posedge clk_i or negedge rst_ni) begin : drive_pixels
    logic             nxt_valid;
    logic [PIX_W-1:0] nxt_pixel;
    logic             nxt_we;
    logic             take;
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel <= '0;
      cfg_we_i     <= 1'b0;
      hold_armed   = 1'b0;
      hold_left    = 0;
      quiet_cycles = 0;
      clear_predictor();
    end else begin
      nxt_valid = pix_if.valid;
      nxt_pixel = pix_if.pixel;
      nxt_we    = 1'b0;
      take      = 1'b0;
      if (pix_if.valid && pix_if.ready) begin
        threshold_step(pix_if.pixel);
        n_accepted++;
        nxt_valid = 1'b0;
      end
      if (mask_q.size() != 0 || pix_if.valid) quiet_cycles = 0;
      else if (quiet_cycles < SETTLE) quiet_cycles++;
      if (!nxt_valid && feed_q.size() != 0) begin
        if (!hold_armed) begin
          hold_left  = feed_q[0].hold;
          hold_armed = 1'b1;
        end
        if (hold_left != 0) begin
          hold_left--;
        end else begin
          case (feed_q[0].kind)
            STEP_PIXEL: begin
              nxt_valid = 1'b1;
              nxt_pixel = feed_q[0].pixel;
              take      = 1'b1;
            end
            STEP_WRITE: begin
              nxt_we     = 1'b1;
              cfg_idx_i  <= feed_q[0].idx;
              cfg_data_i <= feed_q[0].data;
              apply_write(feed_q[0].idx, feed_q[0].data);
              n_writes++;
              take = 1'b1;
            end
            default: take = (mask_q.size() == 0 && quiet_cycles >= SETTLE);
          endcase
          if (take) begin
            void'(feed_q.pop_front());
            hold_armed = 1'b0;
          end
        end
      end
      pix_if.valid <= nxt_valid;
      pix_if.pixel <= nxt_pixel;
      cfg_we_i     <= nxt_we;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : take_masks
    res_t seen;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen.mask_value = res_if.mask_value;
        seen.frame_end  = res_if.frame_end;
        check_mask(seen);
        n_results++;
        // Change the stall pattern now and then so bursts and gaps both occur.
        if (n_results % 64 == 0) sink_pace = pace_e'($urandom_range(0, 2));
        stall_left = draw_pause(sink_pace);
      end
      if (stall_left != 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d masks still expected", cycle_cnt, mask_q.size());
    $display("tb_local_mean_threshold failed");
    $finish;
  end

  initial begin
    int unsigned           w, h, len, pause_at, kind, phase;
    fill_e                 fill;
    pace_e                 pace;
    logic [PIX_W-1:0]      base;
    logic [CFG_DATA_W-1:0] wdata;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    res_if.ready = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_IMAGE_WIDTH;
    cfg_data_i   = '0;

    // Small frame with a bright spike, a dim center and a bright corner.
    push_write(REG_IMAGE_WIDTH, CFG_DATA_W'(8));
    push_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(8));
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++)
        push_pixel((x == 3 && y == 3) ? PIX_MAX[PIX_W-1:0] :
                   (x == 4 && y == 4) ? 8'd1 :
                   (x >= 5 && y >= 6) ? PIX_MAX[PIX_W-1:0] : 8'd0, PACE_STEADY);

    // Zero width and height count as one; an oversized width saturates.
    push_drain();
    push_write(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
    push_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
    push_pixel(PIX_W'(0), PACE_LIGHT);
    push_pixel(PIX_MAX[PIX_W-1:0], PACE_LIGHT);
    push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), PACE_LIGHT);
    push_drain();
    push_write(REG_IMAGE_WIDTH, {CFG_DATA_W{1'b1}});
    push_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(7));
    for (int i = 0; i < 5; i++) push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), PACE_LIGHT);

    // Partial frame cut short by a write to an unused index, then a flat bright frame.
    push_drain();
    push_write(REG_IMAGE_WIDTH, CFG_DATA_W'(7));
    for (int i = 0; i < 12; i++) push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), PACE_HEAVY);
    push_drain();
    push_write(REG_UNUSED_2, CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
    for (int i = 0; i < 49; i++) push_pixel(PIX_MAX[PIX_W-1:0], PACE_STEADY);
    push_drain();
    push_write(REG_UNUSED_3, CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));

    phase = 0;
    while (n_pixels < TARGET_PIX) begin
      pace = pace_e'($urandom_range(0, 2));
      fill = fill_e'($urandom_range(0, 2));
      base = PIX_W'($urandom_range(0, PIX_MAX));
      kind = (phase == 0) ? 1 : (phase == 1) ? 2 : $urandom_range(0, 11);
      case (kind)
        0: begin
          // Too small in one direction: positions wrap but nothing comes out.
          if ($urandom_range(0, 1)) begin
            w = $urandom_range(0, NLINES);
            h = $urandom_range(0, 20);
          end else begin
            w = $urandom_range(NLINES + 1, 12);
            h = $urandom_range(0, NLINES);
          end
          wdata = CFG_DATA_W'(w);
          len   = $urandom_range(20, 60);
        end
        1: begin
          w     = $urandom_range(NLINES + 1, NLINES + 3);
          h     = (1 << HEIGHT_REG_W) - 1;
          wdata = CFG_DATA_W'(w);
          len   = w * $urandom_range(NLINES + 1, NLINES + 4);
        end
        2: begin
          wdata = CFG_DATA_W'((phase == 1) ? MAXW :
                              $urandom_range(MAXW, (1 << WIDTH_REG_W) - 1));
          h     = $urandom_range(NLINES + 1, 12);
          len   = $urandom_range(40, 200);
        end
        default: begin
          w     = $urandom_range(NLINES + 1, 16);
          h     = $urandom_range(NLINES + 1, 12);
          wdata = CFG_DATA_W'(w);
          len   = w * h * $urandom_range(1, 2);
          if ($urandom_range(0, 3) == 0) len = $urandom_range(1, len);
        end
      endcase
      // Keep the total close to the planned pixel count.
      if (len > TARGET_PIX - n_pixels) len = TARGET_PIX - n_pixels;
      push_drain();
      if ($urandom_range(0, 3) == 0)
        push_write($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                   CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
      if ($urandom_range(0, 1)) begin
        push_write(REG_IMAGE_WIDTH, wdata);
        push_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      end else begin
        push_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        push_write(REG_IMAGE_WIDTH, wdata);
      end
      pause_at = ($urandom_range(0, 2) == 0 && len > 1) ? $urandom_range(1, len - 1) : len;
      for (int i = 0; i < len; i++) begin
        if (i == pause_at) push_drain();
        push_pixel(pick_pixel(fill, base), pace);
      end
      phase++;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      while (feed_q.size() != 0 || pix_if.valid || mask_q.size() != 0) @(posedge clk_i);
      repeat (SETTLE) @(posedge clk_i);
    end while (feed_q.size() != 0 || pix_if.valid || mask_q.size() != 0);

    $display("Sent %0d pixels under %0d register writes and checked %0d masks.",
             n_accepted, n_writes, n_results);
    $display("Frames ranged from degenerate sizes up to the widest and tallest settings.");
    if (n_failures == 0) begin
      $display("tb_local_mean_threshold passed");
    end else begin
      $display("%0d failures", n_failures);
      $display("tb_local_mean_threshold failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/lmt_pkg.sv
src/lmt_stream_if.sv
src/lmt_ram.sv
src/lmt_linebuf.sv
src/lmt_window.sv
src/lmt_outq.sv
src/local_mean_threshold.sv
bench/tb_local_mean_threshold.sv
